@@ rtl/first_fit_bin_placement_unit_macros.svh @@
// Assertion macros shared by the first-fit bin placement RTL.
`ifndef FIRST_FIT_BIN_PLACEMENT_UNIT_MACROS_SVH
`define FIRST_FIT_BIN_PLACEMENT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FFBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FFBP_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define FFBP_ASSERT(name, prop, msg)
`define FFBP_ASSERT_IMPLY(name, ante, cons, msg)
`endif
`endif

@@ rtl/ffbp_pkg.sv @@
// Types and constants of the first-fit bin placement unit.
package ffbp_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned BIN_INDEX_W = 10;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic request;
    logic root_chk;
    logic descend;
    logic ascend;
    logic emit;
  } ffbp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic load_ok;
    logic root_fit;
    logic leaf_next;
    logic top_reached;
    logic is_req;
    logic out_free;
  } ffbp_sts_t;

endpackage

@@ rtl/ffbp_ifs.sv @@
// Valid/ready channel interfaces for items and results.
interface ffbp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ffbp_pkg::DATA_W-1:0]   bin_capacity;
  logic [ffbp_pkg::DATA_W-1:0]   request_size;

  modport source (output valid, output kind, output bin_capacity, output request_size,
                  input ready);
  modport sink (input valid, input kind, input bin_capacity, input request_size,
                output ready);
endinterface

interface ffbp_out_if;
  logic                               valid;
  logic                               ready;
  logic                               placed;
  logic [ffbp_pkg::BIN_INDEX_W-1:0]   bin_index;
  logic [ffbp_pkg::DATA_W-1:0]        unplaced_count;

  modport source (output valid, output placed, output bin_index, output unplaced_count,
                  input ready);
  modport sink (input valid, input placed, input bin_index, input unplaced_count,
                output ready);
endinterface

@@ rtl/first_fit_bin_placement_unit.sv @@
// First-fit bin placement unit: top level joining controller and datapath.
// Usage:
//   in_i  carries items: kind 0 loads bin_capacity into the next free bin (no
//         result; ignored once MAX_BINS bins are loaded), kind 1 places
//         request_size into the leftmost unused bin that fits.
//   out_o carries one result per request: placed, bin_index, unplaced_count.
//   Bins sit in a max tree of 2*L words, L = MAX_BINS rounded up to a power of
//   two, held in one memory with one write and one registered read per cycle.
//   Sequence: a request checks the root, descends one level per cycle to the
//     chosen leaf and zeroes it, then updates the maxima one level per cycle
//     back to the root, and waits until the result register has room; a
//     request that misses goes from the root check straight to the result;
//     a load writes its leaf and runs the same update; a load past a full
//     store is accepted and ignored.
//   One item is in flight at a time; in_i.ready is high only when idle.
//   Reset: a clearing pass writes zero to all 2*L tree words, one per cycle,
//   before the first item is accepted.
//   A stalled out_o holds its result; the next item is still accepted, and a
//   request waits for the result register to drain before its result is loaded.
module first_fit_bin_placement_unit #(
  parameter int unsigned MAX_BINS = 1024
) (
  input logic         clk_i,
  input logic         rst_ni,
  ffbp_in_if.sink     in_i,
  ffbp_out_if.source  out_o
);
  import ffbp_pkg::*;

  ffbp_cmd_t cmd;
  ffbp_sts_t sts;
  logic      in_ready;

  ffbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffbp_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_bin_capacity_i    (in_i.bin_capacity),
    .in_request_size_i    (in_i.request_size),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_o.valid),
    .out_ready_i          (out_o.ready),
    .out_placed_o         (out_o.placed),
    .out_bin_index_o      (out_o.bin_index),
    .out_unplaced_count_o (out_o.unplaced_count)
  );

  assign in_i.ready = in_ready;

endmodule

@@ rtl/ffbp_ctrl.sv @@
// Controller state machine sequencing clear, load, descent and update of the max tree.
`include "first_fit_bin_placement_unit_macros.svh"
module ffbp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_kind_i,
  output logic                in_ready_o,
  input  ffbp_pkg::ffbp_sts_t sts_i,
  output ffbp_pkg::ffbp_cmd_t cmd_o
);
  import ffbp_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_ROOT    = 6'b000100,
    S_DESCEND = 6'b001000,
    S_ASCEND  = 6'b010000,
    S_RESULT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_kind_i == KIND_REQUEST) begin
            cmd_o.request = 1'b1;
            state_d       = S_ROOT;
          end else if (sts_i.load_ok) begin
            cmd_o.load = 1'b1;
            state_d    = S_ASCEND;
          end
        end
      end
      S_ROOT: begin
        cmd_o.root_chk = 1'b1;
        state_d        = sts_i.root_fit ? S_DESCEND : S_RESULT;
      end
      S_DESCEND: begin
        cmd_o.descend = 1'b1;
        if (sts_i.leaf_next) state_d = S_ASCEND;
      end
      S_ASCEND: begin
        cmd_o.ascend = 1'b1;
        if (sts_i.top_reached) state_d = sts_i.is_req ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `FFBP_ASSERT_IMPLY(a_req_enters_root, accept && (in_kind_i == KIND_REQUEST),
                     ##1 (state_q == S_ROOT), "request transfer did not start descent")
  `FFBP_ASSERT_IMPLY(a_leaf_starts_update, (state_q == S_DESCEND) && sts_i.leaf_next,
                     ##1 (state_q == S_ASCEND), "leaf reached without tree update")
  `FFBP_ASSERT_IMPLY(a_emit_needs_room, cmd_o.emit, sts_i.out_free,
                     "result emitted over a pending result")

endmodule

@@ rtl/ffbp_datapath.sv @@
// Datapath: max-tree memory, walk registers, load pointer, miss counter, result register.
`include "first_fit_bin_placement_unit_macros.svh"
module ffbp_datapath #(
  parameter int unsigned MAX_BINS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [ffbp_pkg::DATA_W-1:0]      in_bin_capacity_i,
  input  logic [ffbp_pkg::DATA_W-1:0]      in_request_size_i,
  input  ffbp_pkg::ffbp_cmd_t              cmd_i,
  output ffbp_pkg::ffbp_sts_t              sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_placed_o,
  output logic [ffbp_pkg::BIN_INDEX_W-1:0] out_bin_index_o,
  output logic [ffbp_pkg::DATA_W-1:0]      out_unplaced_count_o
);
  import ffbp_pkg::*;

  localparam int unsigned LOG    = $clog2(MAX_BINS);
  localparam int unsigned LEAVES = 1 << LOG;
  localparam int unsigned ADDR_W = LOG + 1;
  localparam int unsigned DEPTH  = 2 * LEAVES;
  localparam int unsigned PTR_W  = $clog2(MAX_BINS + 1);

  logic [DATA_W-1:0]      mem [DEPTH];
  logic [DATA_W-1:0]      rdata_q;
  logic [ADDR_W-1:0]      rd_addr, wr_addr;
  logic                   wr_en;
  logic [DATA_W-1:0]      wr_data;

  logic [ADDR_W-1:0]      node_q, node_d;
  logic [DATA_W-1:0]      val_q, val_d;
  logic [DATA_W-1:0]      size_q;
  logic                   is_req_q;
  logic                   found_q;
  logic [LOG-1:0]         hit_q;
  logic [PTR_W-1:0]       ptr_q;
  logic [DATA_W-1:0]      miss_q;
  logic [ADDR_W-1:0]      clr_q;

  logic                   out_valid_q;
  logic                   out_placed_q;
  logic [BIN_INDEX_W-1:0] out_idx_q;
  logic [DATA_W-1:0]      out_count_q;

  logic                   fit;
  logic [ADDR_W-1:0]      down_node, parent, load_node;
  logic [DATA_W-1:0]      up_val;

  assign fit       = (rdata_q >= size_q);
  assign down_node = {node_q[LOG-1:0], ~fit};
  assign parent    = {1'b0, node_q[ADDR_W-1:1]};
  assign load_node = {1'b1, ptr_q[LOG-1:0]};
  assign up_val    = (rdata_q > val_q) ? rdata_q : val_q;

  always_comb begin
    rd_addr = parent ^ ADDR_W'(1);
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = '0;
    node_d  = node_q;
    val_d   = val_q;
    if (cmd_i.clr_step) begin
      wr_en = 1'b1;
    end
    if (cmd_i.load) begin
      wr_en   = 1'b1;
      wr_addr = load_node;
      wr_data = in_bin_capacity_i;
      node_d  = load_node;
      val_d   = in_bin_capacity_i;
      rd_addr = load_node ^ ADDR_W'(1);
    end
    if (cmd_i.request) begin
      rd_addr = ADDR_W'(1);
      node_d  = ADDR_W'(1);
    end
    if (cmd_i.root_chk) begin
      rd_addr = ADDR_W'(2);
    end
    if (cmd_i.descend) begin
      node_d = down_node;
      if (node_q[LOG-1]) begin
        wr_en   = 1'b1;
        wr_addr = down_node;
        wr_data = '0;
        val_d   = '0;
        rd_addr = down_node ^ ADDR_W'(1);
      end else begin
        rd_addr = {down_node[LOG-1:0], 1'b0};
      end
    end
    if (cmd_i.ascend) begin
      wr_en   = 1'b1;
      wr_addr = parent;
      wr_data = up_val;
      node_d  = parent;
      val_d   = up_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    val_q  <= val_d;
    if (cmd_i.request) size_q <= (in_request_size_i == '0) ? DATA_W'(1) : in_request_size_i;
    if (cmd_i.load || cmd_i.request) is_req_q <= cmd_i.request;
    if (cmd_i.root_chk) found_q <= fit;
    if (cmd_i.descend && node_q[LOG-1]) hit_q <= down_node[LOG-1:0];
    if (cmd_i.emit) begin
      out_placed_q <= found_q;
      out_idx_q    <= found_q ? BIN_INDEX_W'(hit_q) : '0;
      out_count_q  <= miss_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      miss_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + ADDR_W'(1);
      if (cmd_i.load) ptr_q <= ptr_q + PTR_W'(1);
      if (cmd_i.root_chk && !fit && (miss_q != '1)) miss_q <= miss_q + DATA_W'(1);
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_done    = (clr_q == '1);
  assign sts_o.load_ok     = (ptr_q < PTR_W'(MAX_BINS));
  assign sts_o.root_fit    = fit;
  assign sts_o.leaf_next   = node_q[LOG-1];
  assign sts_o.top_reached = (parent == ADDR_W'(1));
  assign sts_o.is_req      = is_req_q;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o          = out_valid_q;
  assign out_placed_o         = out_placed_q;
  assign out_bin_index_o      = out_idx_q;
  assign out_unplaced_count_o = out_count_q;

  `FFBP_ASSERT(a_miss_never_drops, miss_q >= $past(miss_q),
               "miss counter decreased")
  `FFBP_ASSERT(a_ptr_in_range, ptr_q <= PTR_W'(MAX_BINS),
               "load pointer beyond bin count")
  `FFBP_ASSERT_IMPLY(a_miss_index_zero, out_valid_q && !out_placed_q, out_idx_q == '0,
                     "unplaced result carries a bin index")

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the first-fit bin placement unit: table-driven and random items.
module tb_top;
  import ffbp_pkg::*;

  localparam int unsigned NUM_BINS     = 600;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned MAX_IDLE     = 13;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned N_DIRECTED   = 19;

  typedef struct packed {
    logic                   placed;
    logic [BIN_INDEX_W-1:0] bin_index;
    logic [DATA_W-1:0]      unplaced_count;
  } placement_t;

  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] capacity;
    logic [DATA_W-1:0] size;
    logic              typed;
    placement_t        want;
  } directed_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  ffbp_in_if  item_if ();
  ffbp_out_if result_if ();

  first_fit_bin_placement_unit #(
    .MAX_BINS(NUM_BINS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (item_if),
    .out_o (result_if)
  );

  logic [DATA_W-1:0] bin_space_q [NUM_BINS];
  int unsigned       fill_ptr_q;
  logic [DATA_W-1:0] miss_count_q;
  placement_t        expected_placements_q [$];

  int unsigned loads_done;
  int unsigned loads_ignored;
  int unsigned requests_done;
  int unsigned hits_seen;
  int unsigned misses_seen;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned cycle_count;
  bit          sender_done;
  bit          sender_calm;
  bit          receiver_calm;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{KIND_REQUEST, 32'h0000_0000, 32'h0000_0001, 1'b1, '{1'b0, 10'd0, 32'd1}},
    '{KIND_REQUEST, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 10'd0, 32'd2}},
    '{KIND_REQUEST, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd0, 32'd3}},
    '{KIND_LOAD,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
    '{KIND_REQUEST, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 10'd0, 32'd4}},
    '{KIND_LOAD,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{KIND_LOAD,    32'h0000_0001, 32'h0000_0000, 1'b0, '0},
    '{KIND_LOAD,    32'h8000_0000, 32'h0000_0000, 1'b0, '0},
    '{KIND_REQUEST, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 10'd1, 32'd4}},
    '{KIND_REQUEST, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd0, 32'd5}},
    '{KIND_REQUEST, 32'h0000_0000, 32'h0000_0001, 1'b1, '{1'b1, 10'd2, 32'd5}},
    '{KIND_REQUEST, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 10'd3, 32'd5}},
    '{KIND_LOAD,    32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{KIND_LOAD,    32'h5555_5555, 32'h0000_0000, 1'b0, '0},
    '{KIND_LOAD,    32'hAAAA_AAAA, 32'h0000_0000, 1'b0, '0},
    '{KIND_REQUEST, 32'h0000_0000, 32'h5555_5556, 1'b0, '0},
    '{KIND_REQUEST, 32'h0000_0000, 32'h8000_0000, 1'b0, '0},
    '{KIND_REQUEST, 32'h0000_0000, 32'h5555_5555, 1'b0, '0},
    '{KIND_REQUEST, 32'h0000_0000, 32'h0000_0001, 1'b1, '{1'b0, 10'd0, 32'd6}}
  };

  function automatic placement_t first_fit_place(input logic [DATA_W-1:0] size);
    placement_t        res;
    logic [DATA_W-1:0] need;
    int unsigned       k;
    res  = '0;
    need = (size == '0) ? DATA_W'(1) : size;
    for (k = 0; k < NUM_BINS; k++) begin
      if (bin_space_q[k] >= need) begin
        res.placed    = 1'b1;
        res.bin_index = k[BIN_INDEX_W-1:0];
        bin_space_q[k] = '0;
        break;
      end
    end
    if (!res.placed && miss_count_q != '1) begin
      miss_count_q++;
    end
    res.unplaced_count = miss_count_q;
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] draw_operand();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom();
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  task automatic drive_item(input kind_e kind, input logic [DATA_W-1:0] capacity,
                            input logic [DATA_W-1:0] size, input logic typed,
                            input placement_t want);
    int unsigned idle;
    placement_t  got;
    idle = sender_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (idle != 0) begin
      item_if.valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    item_if.valid        <= 1'b1;
    item_if.kind         <= kind;
    item_if.bin_capacity <= capacity;
    item_if.request_size <= size;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    if (kind == KIND_LOAD) begin
      if (fill_ptr_q < NUM_BINS) begin
        bin_space_q[fill_ptr_q] = capacity;
        fill_ptr_q++;
        loads_done++;
      end else begin
        loads_ignored++;
      end
    end else begin
      got = first_fit_place(size);
      requests_done++;
      expected_placements_q.push_back(typed ? want : got);
    end
    @(negedge clk_i);
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
  endtask

  task automatic check_placement(input placement_t got);
    placement_t want;
    results_seen++;
    if (got.placed) hits_seen++;
    else misses_seen++;
    if (expected_placements_q.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("unexpected result: placed=%0b bin_index=%0d unplaced_count=%0d",
                 got.placed, got.bin_index, got.unplaced_count);
      end
    end else begin
      want = expected_placements_q.pop_front();
      if (got.placed !== want.placed || got.bin_index !== want.bin_index ||
          got.unplaced_count !== want.unplaced_count) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("mismatch on result %0d: placed exp %0b got %0b, bin_index exp %0d got %0d,",
                   results_seen, want.placed, got.placed, want.bin_index, got.bin_index);
          $display("  unplaced_count exp %0d got %0d", want.unplaced_count, got.unplaced_count);
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned counted;
    int unsigned row;
    bit          is_load;
    item_if.valid        = 1'b0;
    item_if.kind         = KIND_LOAD;
    item_if.bin_capacity = '0;
    item_if.request_size = '0;
    fill_ptr_q   = 0;
    miss_count_q = '0;
    for (row = 0; row < NUM_BINS; row++) bin_space_q[row] = '0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    for (row = 0; row < N_DIRECTED; row++) begin
      drive_item(directed_rows[row].kind, directed_rows[row].capacity,
                 directed_rows[row].size, directed_rows[row].typed, directed_rows[row].want);
    end
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (fill_ptr_q < NUM_BINS) is_load = ($urandom_range(0, 99) < 60);
      else is_load = ($urandom_range(0, 99) < 5);
      if (!(is_load && fill_ptr_q >= NUM_BINS)) counted++;
      drive_item(is_load ? KIND_LOAD : KIND_REQUEST, draw_operand(), draw_operand(),
                 1'b0, '0);
    end
    item_if.valid <= 1'b0;
    sender_done = 1'b1;
  end

  initial begin
    int unsigned stall;
    int unsigned held;
    bit          hold_done;
    placement_t  got;
    result_if.ready = 1'b0;
    hold_done       = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (results_seen == HOLD_AT && !hold_done) begin
        // hold off long enough for the unit to back up onto its input
        hold_done = 1'b1;
        result_if.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk_i);
          held++;
        end
      end else begin
        stall = receiver_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (stall != 0) begin
          result_if.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_if.valid) @(posedge clk_i);
      got.placed         = result_if.placed;
      got.bin_index      = result_if.bin_index;
      got.unplaced_count = result_if.unplaced_count;
      check_placement(got);
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
    end
  end

  initial begin
    wait (sender_done);
    while (expected_placements_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    error_count += expected_placements_q.size();
    $display("covered %0d loads (%0d past a full store), %0d requests over %0d bins",
             loads_done, loads_ignored, requests_done, NUM_BINS);
    $display("saw %0d placements and %0d misses, %0d errors", hits_seen, misses_seen,
             error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
